/* rtl/srt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_pkg
// shared types and constants of the server registry table
// ----------------------------------------------------------------------------
package srt_pkg;

   localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;
   localparam logic [31:0] TIMEOUT_RESET = 32'd300000;

   localparam logic [1:0] OP_REGISTER = 2'd0;
   localparam logic [1:0] OP_REMOVE   = 2'd1;
   localparam logic [1:0] OP_LIST     = 2'd2;
   localparam logic [1:0] OP_OTHER    = 2'd3;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // result of the shared entry compare unit
   typedef struct packed {
      logic peer;     // address and port equal the item's peer
      logic free;     // address is zero
      logic expired;  // last-seen time is past the timeout
   } flags_type;

   typedef enum logic [16:0] {
      ST_CLEAR     = 17'h00001,
      ST_IDLE      = 17'h00002,
      ST_REG_GAME  = 17'h00004,
      ST_REG_SCAN  = 17'h00008,
      ST_REG_FIN   = 17'h00010,
      ST_REM_GAME  = 17'h00020,
      ST_REM_SCAN  = 17'h00040,
      ST_FILT      = 17'h00080,
      ST_PEER_GAME = 17'h00100,
      ST_PEER_SCAN = 17'h00200,
      ST_EMIT_GAME = 17'h00400,
      ST_EMIT_SCAN = 17'h00800,
      ST_TERM      = 17'h01000,
      ST_SWP_CHK   = 17'h02000,
      ST_SWP_GAME  = 17'h04000,
      ST_SWP_SCAN  = 17'h08000,
      ST_SPARE     = 17'h10000
   } state_type;

endpackage

/* rtl/server_registry_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// server_registry_table_top
// two-level game server registry with register, remove, list and timeout sweep
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until all its work is done. Results appear at most one per cycle on rsp_*
// with rsp_valid high for exactly one cycle and must be taken then: the
// receiver cannot hold them off. Register and remove give one result, a list
// gives up to ENTRIES_PER_REPLY entries plus a terminator when short, other
// packets give none. All work walks the entry tables one entry per cycle
// through one shared compare unit fed by the registered ram read port. A pass
// visits the game slots in order and scans their entries; an item runs one
// pass for its operation (two for a list whose start peer is not found) and
// one more for the timeout sweep when it is due. After reset a clearing pass
// over all GAME_SLOTS * SERVERS_PER_GAME entries frees every entry before the
// first item is taken; the timeout register takes a csr_* transfer only while
// the block is idle (csr_ready is low while busy).
// ----------------------------------------------------------------------------
module server_registry_table_top #(
   parameter int GAME_SLOTS        = 16,
   parameter int SERVERS_PER_GAME  = 64,
   parameter int ENTRIES_PER_REPLY = 32
) (
   input  logic        clock,
   input  logic        reset,
   // item command
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_game_key,
   input  logic        req_use_game_filter,
   input  logic [31:0] req_peer_ip,
   input  logic [15:0] req_peer_port,
   input  logic [31:0] req_time_ms,
   // results
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic [31:0] rsp_entry_ip,
   output logic [15:0] rsp_entry_port,
   output logic        rsp_last,
   // timeout register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);

   // table geometry
   localparam int TOTAL = GAME_SLOTS * SERVERS_PER_GAME;
   localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int GW    = (GAME_SLOTS > 1) ? $clog2(GAME_SLOTS) : 1;
   localparam int GCW   = $clog2(GAME_SLOTS + 1);
   localparam int SCW   = $clog2(SERVERS_PER_GAME + 1);
   localparam int NCW   = $clog2(ENTRIES_PER_REPLY + 1);

   localparam logic [AW-1:0]  STRIDE   = AW'(SERVERS_PER_GAME);
   localparam logic [AW-1:0]  LAST_OFS = AW'(SERVERS_PER_GAME - 1);
   localparam logic [AW-1:0]  LAST_E   = AW'(TOTAL - 1);
   localparam logic [SCW-1:0] S_LAST   = SCW'(SERVERS_PER_GAME - 1);
   localparam logic [SCW-1:0] S_END    = SCW'(SERVERS_PER_GAME);
   localparam logic [GCW-1:0] G_END    = GCW'(GAME_SLOTS);
   localparam logic [NCW-1:0] N_LAST   = NCW'(ENTRIES_PER_REPLY - 1);

   srt_pkg::state_type state_ff, state_in;

   // scan position
   logic [GCW-1:0] g_ff, g_in;
   logic [AW-1:0]  base_ff, base_in;
   logic [SCW-1:0] s_ff, s_in;
   logic [AW-1:0]  cur_ff, cur_in;
   logic [AW-1:0]  clr_ff, clr_in;

   // per-item control
   logic           found_ff, found_in;
   logic           have_ff, have_in;
   logic           own_ff, own_in;
   logic           hit_ff, hit_in;
   logic [SCW-1:0] l_ff, l_in;
   logic [AW-1:0]  tgt_ff, tgt_in;
   logic [NCW-1:0] n_ff, n_in;
   logic [GCW-1:0] fi_ff, fi_in;
   logic [AW-1:0]  fib_ff, fib_in;
   logic           stat_ff, stat_in;

   // item payload
   logic [1:0]  op_ff, op_in;
   logic [31:0] key_item_ff, key_item_in;
   logic        filt_ff, filt_in;
   logic [31:0] ip_ff, ip_in;
   logic [15:0] port_ff, port_in;
   logic [31:0] now_ff, now_in;

   // state registers
   logic [31:0] key_ff [GAME_SLOTS];
   logic [31:0] tmo_ff;
   logic [31:0] lst_ff, lst_in;

   // result register
   logic        rsp_v_ff, rsp_v_in;
   logic        rsp_st_ff, rsp_st_in;
   logic [31:0] rsp_ip_ff, rsp_ip_in;
   logic [15:0] rsp_pt_ff, rsp_pt_in;
   logic        rsp_last_ff, rsp_last_in;

   // ram ports
   logic          we_ip, we_port, we_time, key_we;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wd_ip, wd_time;
   logic [15:0]   wd_port;
   logic [31:0]   ip_rd, time_rd;
   logic [15:0]   port_rd;

   srt_pkg::flags_type fl;

   // derived scan conditions
   logic          accept;
   logic [GW-1:0] g_idx;
   logic          g_lt;
   logic [31:0]   gk;
   logic          in_range;
   logic          s_last;
   logic [AW-1:0] game_addr;
   logic          peer_nz;
   logic [31:0]   horizon;

   assign accept    = start && !busy;
   assign busy      = (state_ff != srt_pkg::ST_IDLE);
   // the timeout only changes between items
   assign csr_ready = !busy;

   assign g_idx     = g_ff[GW-1:0];
   assign g_lt      = (g_ff < G_END);
   assign gk        = g_lt ? key_ff[g_idx] : 32'd0;
   // games visible to a list: the filtered game, or all before the first empty
   assign in_range  = filt_ff ? (g_ff == fi_ff) : (g_lt && (gk != 32'd0));
   assign s_last    = (s_ff == S_LAST);
   assign game_addr = base_ff + AW'(s_ff);
   assign peer_nz   = (ip_ff != 32'd0) && (port_ff != 16'd0);
   assign horizon   = lst_ff + tmo_ff;

   srt_ram #(.WIDTH(32), .DEPTH(TOTAL)) u_ip_ram (
      .clock   (clock),
      .wr_en   (we_ip),
      .wr_addr (wr_addr),
      .wr_data (wd_ip),
      .rd_addr (rd_addr),
      .rd_data (ip_rd)
   );

   srt_ram #(.WIDTH(16), .DEPTH(TOTAL)) u_port_ram (
      .clock   (clock),
      .wr_en   (we_port),
      .wr_addr (wr_addr),
      .wr_data (wd_port),
      .rd_addr (rd_addr),
      .rd_data (port_rd)
   );

   srt_ram #(.WIDTH(32), .DEPTH(TOTAL)) u_time_ram (
      .clock   (clock),
      .wr_en   (we_time),
      .wr_addr (wr_addr),
      .wr_data (wd_time),
      .rd_addr (rd_addr),
      .rd_data (time_rd)
   );

   // shared compare unit on the entry just read
   srt_eval u_eval (
      .ent_ip    (ip_rd),
      .ent_port  (port_rd),
      .ent_time  (time_rd),
      .peer_ip   (ip_ff),
      .peer_port (port_ff),
      .now       (now_ff),
      .timeout   (tmo_ff),
      .flags     (fl)
   );

   always_comb begin
      state_in    = state_ff;
      g_in        = g_ff;
      base_in     = base_ff;
      s_in        = s_ff;
      cur_in      = cur_ff;
      clr_in      = clr_ff;
      found_in    = found_ff;
      have_in     = have_ff;
      own_in      = own_ff;
      hit_in      = hit_ff;
      l_in        = l_ff;
      tgt_in      = tgt_ff;
      n_in        = n_ff;
      fi_in       = fi_ff;
      fib_in      = fib_ff;
      stat_in     = stat_ff;
      op_in       = op_ff;
      key_item_in = key_item_ff;
      filt_in     = filt_ff;
      ip_in       = ip_ff;
      port_in     = port_ff;
      now_in      = now_ff;
      lst_in      = lst_ff;

      rsp_v_in    = 1'b0;
      rsp_st_in   = srt_pkg::STATUS_OK;
      rsp_ip_in   = 32'd0;
      rsp_pt_in   = 16'd0;
      rsp_last_in = 1'b0;

      we_ip   = 1'b0;
      we_port = 1'b0;
      we_time = 1'b0;
      key_we  = 1'b0;
      wr_addr = cur_ff;
      wd_ip   = 32'd0;
      wd_port = port_ff;
      wd_time = now_ff;
      // while scanning, read one entry ahead of the one being evaluated
      rd_addr = cur_ff + AW'(1);

      unique case (state_ff)
         srt_pkg::ST_CLEAR: begin
            we_ip   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == LAST_E) begin
               state_in = srt_pkg::ST_IDLE;
            end
         end

         srt_pkg::ST_IDLE: begin
            if (accept) begin
               op_in       = req_operation;
               key_item_in = req_game_key;
               filt_in     = req_use_game_filter;
               ip_in       = req_peer_ip;
               port_in     = req_peer_port;
               now_in      = req_time_ms;
               g_in        = '0;
               base_in     = '0;
               s_in        = '0;
               found_in    = 1'b0;
               have_in     = 1'b0;
               hit_in      = 1'b0;
               n_in        = '0;
               case (req_operation)
                  srt_pkg::OP_REGISTER: state_in = srt_pkg::ST_REG_GAME;
                  srt_pkg::OP_REMOVE:   state_in = srt_pkg::ST_REM_GAME;
                  srt_pkg::OP_LIST: begin
                     if (req_use_game_filter) begin
                        state_in = srt_pkg::ST_FILT;
                     end else if ((req_peer_ip != 32'd0) && (req_peer_port != 16'd0)) begin
                        state_in = srt_pkg::ST_PEER_GAME;
                     end else begin
                        state_in = srt_pkg::ST_EMIT_GAME;
                     end
                  end
                  default: state_in = srt_pkg::ST_SWP_CHK;
               endcase
            end
         end

         // register: decide what to do with this game slot
         srt_pkg::ST_REG_GAME: begin
            rd_addr = game_addr;
            if (!g_lt) begin
               state_in = srt_pkg::ST_REG_FIN;
            end else if (!found_ff && (gk == 32'd0)) begin
               key_we   = 1'b1;
               tgt_in   = base_ff + LAST_OFS;
               have_in  = 1'b1;
               state_in = srt_pkg::ST_REG_FIN;
            end else begin
               own_in   = (gk == key_item_ff);
               cur_in   = game_addr;
               s_in     = '0;
               state_in = srt_pkg::ST_REG_SCAN;
            end
         end

         srt_pkg::ST_REG_SCAN: begin
            if (fl.peer) begin
               if (own_ff) begin
                  // refresh the existing entry
                  we_time     = 1'b1;
                  rsp_v_in    = 1'b1;
                  rsp_last_in = 1'b1;
                  state_in    = srt_pkg::ST_SWP_CHK;
               end else begin
                  // evict the peer from another game
                  we_ip    = 1'b1;
                  g_in     = g_ff + GCW'(1);
                  base_in  = base_ff + STRIDE;
                  s_in     = '0;
                  state_in = srt_pkg::ST_REG_GAME;
               end
            end else begin
               if (own_ff && fl.free) begin
                  tgt_in  = cur_ff;
                  have_in = 1'b1;
               end
               if (s_last) begin
                  if (own_ff) begin
                     found_in = 1'b1;
                  end
                  g_in     = g_ff + GCW'(1);
                  base_in  = base_ff + STRIDE;
                  s_in     = '0;
                  state_in = srt_pkg::ST_REG_GAME;
               end else begin
                  s_in   = s_ff + SCW'(1);
                  cur_in = cur_ff + AW'(1);
               end
            end
         end

         srt_pkg::ST_REG_FIN: begin
            if (have_ff) begin
               we_ip   = 1'b1;
               we_port = 1'b1;
               we_time = 1'b1;
               wr_addr = tgt_ff;
               wd_ip   = ip_ff;
            end
            rsp_v_in    = 1'b1;
            rsp_st_in   = have_ff ? srt_pkg::STATUS_OK : srt_pkg::STATUS_FAIL;
            rsp_last_in = 1'b1;
            state_in    = srt_pkg::ST_SWP_CHK;
         end

         srt_pkg::ST_REM_GAME: begin
            rd_addr = game_addr;
            if (!g_lt || (gk == 32'd0)) begin
               rsp_v_in    = 1'b1;
               rsp_st_in   = srt_pkg::STATUS_FAIL;
               rsp_last_in = 1'b1;
               state_in    = srt_pkg::ST_SWP_CHK;
            end else begin
               cur_in   = game_addr;
               s_in     = '0;
               state_in = srt_pkg::ST_REM_SCAN;
            end
         end

         srt_pkg::ST_REM_SCAN: begin
            if (fl.peer) begin
               we_ip       = 1'b1;
               rsp_v_in    = 1'b1;
               rsp_last_in = 1'b1;
               state_in    = srt_pkg::ST_SWP_CHK;
            end else if (s_last) begin
               g_in     = g_ff + GCW'(1);
               base_in  = base_ff + STRIDE;
               s_in     = '0;
               state_in = srt_pkg::ST_REM_GAME;
            end else begin
               s_in   = s_ff + SCW'(1);
               cur_in = cur_ff + AW'(1);
            end
         end

         // list: find the filtered game among the occupied slots
         srt_pkg::ST_FILT: begin
            if (!g_lt || (gk == 32'd0)) begin
               stat_in  = srt_pkg::STATUS_FAIL;
               state_in = srt_pkg::ST_TERM;
            end else if (gk == key_item_ff) begin
               fi_in  = g_ff;
               fib_in = base_ff;
               s_in   = '0;
               if (peer_nz) begin
                  state_in = srt_pkg::ST_PEER_GAME;
               end else begin
                  state_in = srt_pkg::ST_EMIT_GAME;
               end
            end else begin
               g_in    = g_ff + GCW'(1);
               base_in = base_ff + STRIDE;
            end
         end

         // list: locate the start peer, last match in the first game holding it
         srt_pkg::ST_PEER_GAME: begin
            rd_addr = game_addr;
            if (!in_range) begin
               g_in     = filt_ff ? fi_ff : '0;
               base_in  = filt_ff ? fib_ff : '0;
               s_in     = '0;
               state_in = srt_pkg::ST_EMIT_GAME;
            end else begin
               cur_in   = game_addr;
               s_in     = '0;
               hit_in   = 1'b0;
               state_in = srt_pkg::ST_PEER_SCAN;
            end
         end

         srt_pkg::ST_PEER_SCAN: begin
            if (fl.peer) begin
               hit_in = 1'b1;
               l_in   = s_ff + SCW'(1);
            end
            if (s_last) begin
               if (hit_ff || fl.peer) begin
                  s_in     = fl.peer ? S_END : l_ff;
                  state_in = srt_pkg::ST_EMIT_GAME;
               end else begin
                  g_in     = g_ff + GCW'(1);
                  base_in  = base_ff + STRIDE;
                  s_in     = '0;
                  state_in = srt_pkg::ST_PEER_GAME;
               end
            end else begin
               s_in   = s_ff + SCW'(1);
               cur_in = cur_ff + AW'(1);
            end
         end

         // list: stream occupied entries from the current position
         srt_pkg::ST_EMIT_GAME: begin
            rd_addr = game_addr;
            if (!in_range) begin
               stat_in  = srt_pkg::STATUS_OK;
               state_in = srt_pkg::ST_TERM;
            end else if (s_ff == S_END) begin
               g_in    = g_ff + GCW'(1);
               base_in = base_ff + STRIDE;
               s_in    = '0;
            end else begin
               cur_in   = game_addr;
               state_in = srt_pkg::ST_EMIT_SCAN;
            end
         end

         srt_pkg::ST_EMIT_SCAN: begin
            if (!fl.free) begin
               rsp_v_in  = 1'b1;
               rsp_ip_in = ip_rd;
               rsp_pt_in = port_rd;
               n_in      = n_ff + NCW'(1);
            end
            if (!fl.free && (n_ff == N_LAST)) begin
               rsp_last_in = 1'b1;
               state_in    = srt_pkg::ST_SWP_CHK;
            end else if (s_last) begin
               g_in     = g_ff + GCW'(1);
               base_in  = base_ff + STRIDE;
               s_in     = '0;
               state_in = srt_pkg::ST_EMIT_GAME;
            end else begin
               s_in   = s_ff + SCW'(1);
               cur_in = cur_ff + AW'(1);
            end
         end

         srt_pkg::ST_TERM: begin
            rsp_v_in    = 1'b1;
            rsp_st_in   = stat_ff;
            rsp_last_in = 1'b1;
            state_in    = srt_pkg::ST_SWP_CHK;
         end

         // sweep only when the clock moved back or past the horizon
         srt_pkg::ST_SWP_CHK: begin
            if ((lst_ff > now_ff) || (horizon < now_ff)) begin
               g_in     = '0;
               base_in  = '0;
               s_in     = '0;
               state_in = srt_pkg::ST_SWP_GAME;
            end else begin
               state_in = srt_pkg::ST_IDLE;
            end
         end

         srt_pkg::ST_SWP_GAME: begin
            rd_addr = game_addr;
            if (!g_lt || (gk == 32'd0)) begin
               lst_in   = now_ff;
               state_in = srt_pkg::ST_IDLE;
            end else begin
               cur_in   = game_addr;
               s_in     = '0;
               state_in = srt_pkg::ST_SWP_SCAN;
            end
         end

         srt_pkg::ST_SWP_SCAN: begin
            if (fl.expired) begin
               we_ip = 1'b1;
            end
            if (s_last) begin
               g_in     = g_ff + GCW'(1);
               base_in  = base_ff + STRIDE;
               s_in     = '0;
               state_in = srt_pkg::ST_SWP_GAME;
            end else begin
               s_in   = s_ff + SCW'(1);
               cur_in = cur_ff + AW'(1);
            end
         end

         default: begin
            state_in = srt_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srt_pkg::ST_CLEAR;
         clr_ff   <= '0;
         tmo_ff   <= srt_pkg::TIMEOUT_RESET;
         lst_ff   <= 32'd0;
         rsp_v_ff <= 1'b0;
         for (int i = 0; i < GAME_SLOTS; i++) begin
            key_ff[i] <= 32'd0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         lst_ff   <= lst_in;
         rsp_v_ff <= rsp_v_in;
         if (csr_valid && csr_ready) begin
            tmo_ff <= csr_wdata;
         end
         if (key_we) begin
            key_ff[g_idx] <= key_item_ff;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      g_ff        <= g_in;
      base_ff     <= base_in;
      s_ff        <= s_in;
      cur_ff      <= cur_in;
      found_ff    <= found_in;
      have_ff     <= have_in;
      own_ff      <= own_in;
      hit_ff      <= hit_in;
      l_ff        <= l_in;
      tgt_ff      <= tgt_in;
      n_ff        <= n_in;
      fi_ff       <= fi_in;
      fib_ff      <= fib_in;
      stat_ff     <= stat_in;
      op_ff       <= op_in;
      key_item_ff <= key_item_in;
      filt_ff     <= filt_in;
      ip_ff       <= ip_in;
      port_ff     <= port_in;
      now_ff      <= now_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_ip_ff   <= rsp_ip_in;
      rsp_pt_ff   <= rsp_pt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_v_ff;
   assign rsp_status     = rsp_st_ff;
   assign rsp_entry_ip   = rsp_ip_ff;
   assign rsp_entry_port = rsp_pt_ff;
   assign rsp_last       = rsp_last_ff;

   // a result is only shown while its item still holds the block
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result transfer outside an item");

   // an accepted item always holds the block on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("item accepted without going busy");

   // nothing follows the final result of an item at once
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("result right after final result");

   // other packets cause no result at all
   a_other_silent: assert property (@(posedge clock) disable iff (reset)
      (busy && (op_ff == srt_pkg::OP_OTHER) && (state_ff != srt_pkg::ST_CLEAR))
      |-> !rsp_valid)
      else $error("result from an other packet");

endmodule

/* rtl/srt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module srt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* rtl/srt_eval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_eval
// shared entry compare unit: peer match, free test and expiry test
// ----------------------------------------------------------------------------
module srt_eval (
   input  logic [31:0]        ent_ip,
   input  logic [15:0]        ent_port,
   input  logic [31:0]        ent_time,
   input  logic [31:0]        peer_ip,
   input  logic [15:0]        peer_port,
   input  logic [31:0]        now,
   input  logic [31:0]        timeout,
   output srt_pkg::flags_type flags
);

   logic [31:0] wrapped;
   logic [31:0] plain;

   always_comb begin
      wrapped = (srt_pkg::ALL_ONES - ent_time) + timeout;
      plain   = ent_time + timeout;
      flags.peer    = (ent_ip == peer_ip) && (ent_port == peer_port);
      flags.free    = (ent_ip == 32'd0);
      flags.expired = ((ent_time > now) && (wrapped < now)) || (plain < now);
   end

endmodule
